>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers on clk with synchronous reset rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define RSM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// trigger is followed on the next edge by the consequence
`define RSM_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/rsm_pkg.sv
// ---------------------------------------------------------------------------
// rsm_pkg
// Types, codes and sizes shared by the shape mask hit test block.
// ---------------------------------------------------------------------------
package rsm_pkg;

  localparam int SHAPE_WORDS = 4096;
  localparam int MEM_AW      = $clog2(SHAPE_WORDS);
  localparam int BADDR_W     = 18;
  localparam int IDX_W       = BADDR_W - 1;
  localparam int COORD_W     = 34;
  localparam int COL_W       = 29;
  localparam logic [15:0] RUN_END = 16'hFFFF;

  typedef struct packed {
    logic              op;
    logic [11:0]       word_index;
    logic [15:0]       word_value;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
  } rsm_in_t;

  typedef struct packed {
    logic hit;
    logic format_error;
  } rsm_out_t;

  typedef enum logic [2:0] {
    REG_TEX_SHIFT  = 3'd0,
    REG_IMAGE_SIZE = 3'd1,
    REG_TILE_SHIFT = 3'd2,
    REG_TILE_SIZE  = 3'd3,
    REG_DRAW_SIZE  = 3'd4,
    REG_DRAW_MODES = 3'd5,
    REG_SHAPE_LEN  = 3'd6
  } rsm_reg_t;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_CENTRE  = 3'd1,
    MODE_STRETCH = 3'd2,
    MODE_TILE    = 3'd3,
    MODE_STILE   = 3'd4
  } rsm_mode_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_MAP, ST_DIV, ST_SHIFT, ST_F0, ST_F1, ST_F2,
    ST_HDR, ST_ROW, ST_WALK, ST_RUN, ST_DONE
  } rsm_state_t;

  typedef enum logic [1:0] {FT_W, FT_H, FT_OFF, FT_RUN} rsm_fetch_t;

  typedef enum logic [1:0] {BA_W, BA_H, BA_ROW, BA_OFF} rsm_baddr_t;

  typedef struct packed {
    logic       capture;
    logic       mem_write;
    logic       axis;
    logic       map_store;
    logic       div_start;
    logic       div_store;
    logic       add_shift;
    logic       baddr_load;
    rsm_baddr_t baddr_sel;
    logic       rd_hi;
    logic       grab_lo;
    logic       load_w;
    logic       load_h;
    logic       load_word;
    logic       walk_init;
    logic       walk_adv;
    logic       res_load;
    logic       res_hit;
    logic       res_err;
  } rsm_cmd_t;

  typedef struct packed {
    logic draw_zero;
    logic map_miss;
    logic map_accept;
    logic map_div;
    logic div_done;
    logic bounds_miss;
    logic row_empty;
    logic row_bad;
    logic walk_over;
    logic run_end;
    logic run_in;
    logic opaque;
    logic x_lt_w;
  } rsm_sts_t;

endpackage

>>> hw/rtl/rsm_div.sv
// ---------------------------------------------------------------------------
// rsm_div
// Restoring unsigned divider, 32 by 16 bits, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module rsm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [15:0] remainder
);
  logic        run;
  logic [4:0]  cnt;
  logic [15:0] dvs;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;

  assign rem_sh  = {remainder, quotient[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'd31;
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (run) begin
      if (!rem_sub[16]) begin
        remainder <= rem_sub[15:0];
        quotient  <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= rem_sh[15:0];
        quotient  <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

>>> hw/rtl/rsm_datapath.sv
// ---------------------------------------------------------------------------
// rsm_datapath
// Registers, shape memory, axis mapping, divider and run walk arithmetic.
// ---------------------------------------------------------------------------
module rsm_datapath (
  input  logic             clk,
  input  logic             rst,
  input  rsm_pkg::rsm_in_t item,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  input  rsm_pkg::rsm_cmd_t cmd,
  output rsm_pkg::rsm_sts_t sts,
  output rsm_pkg::rsm_out_t result
);
  import rsm_pkg::*;

  logic [31:0] tex_shift, image_size, tile_shift, tile_size, draw_size;
  logic [5:0]  draw_modes;
  logic [13:0] shape_len;

  logic [15:0] mem [SHAPE_WORDS];
  logic [15:0] rdata;
  logic        rd_oob;
  logic [BADDR_W-1:0] rbyte;
  logic [IDX_W-1:0] ridx;

  logic signed [15:0] px, py;
  logic signed [COORD_W-1:0] cx, cy;
  logic [15:0] w, h, fword;
  logic [BADDR_W-1:0] baddr, off;
  logic [7:0]  lo_byte;
  logic [COL_W-1:0] col;
  logic        opaque;
  logic        div_neg, div_strch;

  // axis selection
  logic signed [15:0] v;
  rsm_mode_t   mode;
  logic [15:0] draw, img, tsh, tsz;
  logic signed [19:0] v20, draw20, img20, tsh20, tsz20, d, dround, ofs, e, map_res, vm;
  logic signed [33:0] prod, pmag;
  logic        map_miss, map_accept, map_div;
  logic        div_start_strch;
  logic [31:0] dividend;
  logic [15:0] divisor;
  logic        div_done;
  logic [31:0] quo;
  logic [15:0] rem;
  logic signed [COORD_W-1:0] div_res, w34, h34;
  logic [7:0]  hi_byte;
  logic [29:0] colsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_shift  <= '0;
      image_size <= '0;
      tile_shift <= '0;
      tile_size  <= '0;
      draw_size  <= '0;
      draw_modes <= '0;
      shape_len  <= '0;
    end else if (cfg_we) begin
      case (rsm_reg_t'(cfg_index))
        REG_TEX_SHIFT:  tex_shift  <= cfg_data;
        REG_IMAGE_SIZE: image_size <= cfg_data;
        REG_TILE_SHIFT: tile_shift <= cfg_data;
        REG_TILE_SIZE:  tile_size  <= cfg_data;
        REG_DRAW_SIZE:  draw_size  <= cfg_data;
        REG_DRAW_MODES: draw_modes <= cfg_data[5:0];
        REG_SHAPE_LEN:  shape_len  <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // shape memory
  assign rbyte = baddr + BADDR_W'(cmd.rd_hi);
  assign ridx  = rbyte[BADDR_W-1:1];

  always_ff @(posedge clk) begin
    if (cmd.mem_write && (32'(item.word_index) < SHAPE_WORDS)) begin
      mem[MEM_AW'(item.word_index)] <= item.word_value;
    end
    rdata  <= mem[MEM_AW'(ridx)];
    rd_oob <= 32'(ridx) >= SHAPE_WORDS;
  end

  // axis mapping
  always_comb begin
    if (cmd.axis) begin
      v = py; mode = rsm_mode_t'(draw_modes[5:3]);
      draw = draw_size[31:16]; img = image_size[31:16];
      tsh = tile_shift[31:16]; tsz = tile_size[31:16];
    end else begin
      v = px; mode = rsm_mode_t'(draw_modes[2:0]);
      draw = draw_size[15:0]; img = image_size[15:0];
      tsh = tile_shift[15:0]; tsz = tile_size[15:0];
    end
  end

  assign v20    = $signed({{4{v[15]}}, v});
  assign draw20 = $signed({4'b0, draw});
  assign img20  = $signed({4'b0, img});
  assign tsh20  = $signed({4'b0, tsh});
  assign tsz20  = $signed({4'b0, tsz});
  assign d      = draw20 - img20;
  assign dround = d + (d[19] ? 20'sd1 : 20'sd0);
  assign ofs    = dround >>> 1;
  assign e      = d + tsh20 + tsz20;
  assign vm     = v20 - tsh20;

  always_comb begin
    map_miss        = 1'b0;
    map_accept      = 1'b0;
    map_div         = 1'b0;
    div_start_strch = 1'b0;
    map_res         = v20;
    case (mode)
      MODE_NORMAL: map_miss = v20 > img20;
      MODE_CENTRE: begin
        map_miss = (v20 < ofs) || (v20 >= ofs + img20);
        map_res  = v20 - ofs;
      end
      MODE_STRETCH: begin
        map_div         = 1'b1;
        div_start_strch = 1'b1;
      end
      MODE_TILE: begin
        if (tsz == 16'd0) map_accept = 1'b1;
        else if (v20 >= e) map_res = v20 - draw20 + img20;
        else if (v20 >= tsh20) map_div = 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.map_miss   = map_miss;
  assign sts.map_accept = map_accept;
  assign sts.map_div    = map_div;

  assign prod     = $signed({v[15], v}) * $signed({1'b0, img});
  assign pmag     = prod[33] ? -prod : prod;
  assign dividend = div_start_strch ? pmag[31:0] : {12'b0, vm};
  assign divisor  = div_start_strch ? draw : tsz;

  rsm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (dividend),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_comb begin
    if (div_strch) begin
      div_res = div_neg ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    end else begin
      div_res = $signed({18'b0, tsh}) + $signed({18'b0, rem});
    end
  end

  assign w34     = $signed({18'b0, w});
  assign h34     = $signed({18'b0, h});
  assign hi_byte = rd_oob ? 8'hFF : (baddr[0] ? rdata[7:0] : rdata[15:8]);
  assign colsum  = {1'b0, col} + 30'(fword);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px <= item.point_x;
      py <= item.point_y;
    end
    if (cmd.div_start) begin
      div_neg   <= prod[33];
      div_strch <= div_start_strch;
    end
    if (cmd.map_store) begin
      if (cmd.axis) cy <= COORD_W'(map_res);
      else          cx <= COORD_W'(map_res);
    end
    if (cmd.div_store) begin
      if (cmd.axis) cy <= div_res;
      else          cx <= div_res;
    end
    if (cmd.add_shift) begin
      cx <= cx + $signed({18'b0, tex_shift[15:0]});
      cy <= cy + $signed({18'b0, tex_shift[31:16]});
    end
    if (cmd.baddr_load) begin
      case (cmd.baddr_sel)
        BA_W:   baddr <= BADDR_W'(4);
        BA_H:   baddr <= BADDR_W'(6);
        BA_ROW: baddr <= {1'b0, cy[15:0], 1'b0} + BADDR_W'(8);
        default: baddr <= off;
      endcase
    end
    if (cmd.grab_lo) lo_byte <= rd_oob ? 8'hFF : (baddr[0] ? rdata[15:8] : rdata[7:0]);
    if (cmd.load_w)    w     <= {hi_byte, lo_byte};
    if (cmd.load_h)    h     <= {hi_byte, lo_byte};
    if (cmd.load_word) fword <= {hi_byte, lo_byte};
    if (cmd.walk_init) begin
      off    <= BADDR_W'(fword);
      col    <= '0;
      opaque <= 1'b0;
    end
    if (cmd.walk_adv) begin
      off    <= off + BADDR_W'(2);
      col    <= colsum[COL_W-1:0];
      opaque <= !opaque;
    end
    if (cmd.res_load) begin
      result.hit          <= cmd.res_hit;
      result.format_error <= cmd.res_err;
    end
  end

  assign sts.draw_zero   = (draw_size[15:0] == 16'd0) || (draw_size[31:16] == 16'd0);
  assign sts.div_done    = div_done;
  assign sts.bounds_miss = (cx < 0) || (cx >= w34) || (cy < 0) || (cy >= h34);
  assign sts.row_empty   = fword == RUN_END;
  assign sts.row_bad     = (shape_len < 14'd2) || ({1'b0, fword} + 17'd2 > {3'b0, shape_len});
  assign sts.walk_over   = ({1'b0, off} + 19'd2) > {5'b0, shape_len};
  assign sts.run_end     = fword == RUN_END;
  assign sts.run_in      = 30'(cx[15:0]) < colsum;
  assign sts.opaque      = opaque;
  assign sts.x_lt_w      = cx < w34;
endmodule

>>> hw/rtl/rsm_ctrl.sv
// ---------------------------------------------------------------------------
// rsm_ctrl
// Sequencer for loads, axis mapping, header and row fetches and the run walk.
// ---------------------------------------------------------------------------
module rsm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  rsm_pkg::rsm_sts_t sts,
  output rsm_pkg::rsm_cmd_t cmd,
  output logic              busy,
  output logic              done
);
  import rsm_pkg::*;

  rsm_state_t state, state_next;
  rsm_fetch_t target, target_next;
  logic       axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      target <= FT_W;
      axis   <= 1'b0;
    end else begin
      state  <= state_next;
      target <= target_next;
      axis   <= axis_next;
    end
  end

  always_comb begin
    state_next  = state;
    target_next = target;
    axis_next   = axis;
    case (state)
      ST_IDLE: if (start && op == OP_TEST) state_next = ST_CHECK;
      ST_CHECK: begin
        axis_next  = 1'b0;
        state_next = sts.draw_zero ? ST_DONE : ST_MAP;
      end
      ST_MAP: begin
        if (sts.map_miss || sts.map_accept) state_next = ST_DONE;
        else if (sts.map_div) state_next = ST_DIV;
        else if (axis) state_next = ST_SHIFT;
        else axis_next = 1'b1;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          if (axis) state_next = ST_SHIFT;
          else begin
            axis_next  = 1'b1;
            state_next = ST_MAP;
          end
        end
      end
      ST_SHIFT: begin
        target_next = FT_W;
        state_next  = ST_F0;
      end
      ST_F0: state_next = ST_F1;
      ST_F1: state_next = ST_F2;
      ST_F2: begin
        case (target)
          FT_W: begin
            target_next = FT_H;
            state_next  = ST_F0;
          end
          FT_H:   state_next = ST_HDR;
          FT_OFF: state_next = ST_ROW;
          default: state_next = ST_RUN;
        endcase
      end
      ST_HDR: begin
        if (sts.bounds_miss) state_next = ST_DONE;
        else begin
          target_next = FT_OFF;
          state_next  = ST_F0;
        end
      end
      ST_ROW: state_next = (sts.row_empty || sts.row_bad) ? ST_DONE : ST_WALK;
      ST_WALK: begin
        if (sts.walk_over) state_next = ST_DONE;
        else begin
          target_next = FT_RUN;
          state_next  = ST_F0;
        end
      end
      ST_RUN: state_next = (sts.run_end || sts.run_in) ? ST_DONE : ST_WALK;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.axis      = axis;
    cmd.baddr_sel = BA_W;
    busy          = state != ST_IDLE;
    done          = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.capture   = start;
        cmd.mem_write = start && op == OP_LOAD;
      end
      ST_CHECK: begin
        cmd.res_load = 1'b1;
      end
      ST_MAP: begin
        cmd.res_load  = sts.map_accept;
        cmd.res_hit   = 1'b1;
        cmd.div_start = sts.map_div && !sts.map_miss && !sts.map_accept;
        cmd.map_store = !sts.map_miss && !sts.map_accept && !sts.map_div;
      end
      ST_DIV: cmd.div_store = sts.div_done;
      ST_SHIFT: begin
        cmd.add_shift  = 1'b1;
        cmd.baddr_load = 1'b1;
        cmd.baddr_sel  = BA_W;
      end
      ST_F0: ;
      ST_F1: begin
        cmd.rd_hi   = 1'b1;
        cmd.grab_lo = 1'b1;
      end
      ST_F2: begin
        cmd.load_w     = target == FT_W;
        cmd.load_h     = target == FT_H;
        cmd.load_word  = target == FT_OFF || target == FT_RUN;
        cmd.baddr_load = target == FT_W;
        cmd.baddr_sel  = BA_H;
      end
      ST_HDR: begin
        cmd.baddr_load = 1'b1;
        cmd.baddr_sel  = BA_ROW;
      end
      ST_ROW: begin
        cmd.res_load  = sts.row_bad && !sts.row_empty;
        cmd.res_err   = 1'b1;
        cmd.walk_init = 1'b1;
      end
      ST_WALK: begin
        cmd.baddr_load = 1'b1;
        cmd.baddr_sel  = BA_OFF;
      end
      ST_RUN: begin
        if (sts.run_end) begin
          cmd.res_load = 1'b1;
          cmd.res_hit  = sts.x_lt_w && sts.opaque;
        end else if (sts.run_in) begin
          cmd.res_load = 1'b1;
          cmd.res_hit  = sts.opaque;
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end
      ST_DONE: done = 1'b1;
      default: ;
    endcase
  end
endmodule

>>> hw/rtl/rle_shape_mask_hit_test.sv
// ---------------------------------------------------------------------------
// rle_shape_mask_hit_test
// Run-length shape mask store with point hit test.
// ---------------------------------------------------------------------------
// channel   signals                               beat taken when
// item      start, busy, item                      start && !busy
// result    done, result                           done (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, data  cfg_valid && cfg_ready
//
// A load beat is taken without leaving idle and gives no result. A test
// maps both axes, dividing on each axis in stretch or tile modulo mode
// (in the shared bit-serial divider), then reads the header, row offset
// and runs, each memory word in states F0, F1 and F2 on the single read
// port. No clearing pass after reset. The result cannot be stalled; busy holds the item side off.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rle_shape_mask_hit_test (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rsm_pkg::rsm_in_t  item,
  output logic              done,
  output rsm_pkg::rsm_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import rsm_pkg::*;

  rsm_cmd_t cmd;
  rsm_sts_t sts;

  assign cfg_ready = !busy;

  rsm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rsm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  `RSM_ASSERT_NEXT(a_done_single, done, !done)
  `RSM_ASSERT(a_done_busy, !done || busy)
  `RSM_ASSERT(a_err_no_hit, !(done && result.format_error) || !result.hit)
  `RSM_ASSERT_NEXT(a_load_no_busy, start && !busy && item.op == OP_LOAD, !busy)
endmodule
